### sv/tli_pkg.sv
`default_nettype none
package tli_pkg;

   localparam int NumRegs    = 15;
   localparam int RegIdxW    = 4;
   localparam int DataW      = 32;
   localparam int QueueDepth = 2;   // power of two, pointers wrap naturally
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   localparam logic [RegIdxW-1:0] PC_REG = 4'd15;

   // instruction codes as they arrive on the request channel
   typedef enum logic [2:0] {
      OP_TST = 3'd0,
      OP_AND = 3'd1,
      OP_BIC = 3'd2,
      OP_MOV = 3'd3,
      OP_ORR = 3'd4
   } tli_opcode_type;

   // operation carried out by the back end
   typedef enum logic [1:0] {
      LOGIC_AND,
      LOGIC_BIC,
      LOGIC_MOV,
      LOGIC_ORR
   } tli_logic_op_type;

   // classified instruction, front to back
   typedef struct packed {
      logic                 reject;      // PC use or unused opcode
      logic                 write_reg;
      logic                 set_flags;
      logic                 keep_carry;  // replicated pattern: C passes through
      logic                 rot_carry;   // rotated pattern: bit 31 of immediate
      tli_logic_op_type     logic_op;
      logic [RegIdxW-1:0]   src;
      logic [RegIdxW-1:0]   dest;
      logic [DataW-1:0]     imm;
   } tli_cmd_type;

endpackage
`default_nettype wire

### sv/tli_channels.sv
`default_nettype none
interface tli_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic       set_flags;
   logic [3:0] source_reg;
   logic [3:0] dest_reg;
   logic       imm_top_bit;
   logic [2:0] imm_mid_bits;
   logic [7:0] imm_low_byte;

   modport source (output valid, opcode, set_flags, source_reg, dest_reg,
                   imm_top_bit, imm_mid_bits, imm_low_byte, input ready);
   modport sink   (input valid, opcode, set_flags, source_reg, dest_reg,
                   imm_top_bit, imm_mid_bits, imm_low_byte, output ready);
endinterface

interface tli_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        reg_written;
   logic        negative_flag;
   logic        zero_flag;
   logic        carry_flag;
   logic        unpredictable;

   modport source (output valid, result_value, reg_written, negative_flag,
                   zero_flag, carry_flag, unpredictable, input ready);
   modport sink   (input valid, result_value, reg_written, negative_flag,
                   zero_flag, carry_flag, unpredictable, output ready);
endinterface
`default_nettype wire

### sv/tli_front.sv
`default_nettype none
module tli_front (
   tli_req_if.sink              req_chan,
   input  logic                 queue_full,
   output logic                 push,
   output tli_pkg::tli_cmd_type cmd
);

   logic [11:0] imm12;
   logic [31:0] rot_base;
   logic [63:0] rot_dbl;
   logic [31:0] rot_val;
   logic [31:0] rep_val;
   logic [7:0]  b;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   assign imm12    = {req_chan.imm_top_bit, req_chan.imm_mid_bits, req_chan.imm_low_byte};
   assign b        = req_chan.imm_low_byte;
   assign rot_base = {24'd0, 1'b1, b[6:0]};
   assign rot_dbl  = {rot_base, rot_base} >> imm12[11:7];
   assign rot_val  = rot_dbl[31:0];

   always_comb begin
      unique case (imm12[9:8])
         2'd0:    rep_val = {24'd0, b};
         2'd1:    rep_val = {8'd0, b, 8'd0, b};
         2'd2:    rep_val = {b, 8'd0, b, 8'd0};
         default: rep_val = {b, b, b, b};
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.src        = req_chan.source_reg;
      cmd.dest       = req_chan.dest_reg;
      cmd.set_flags  = req_chan.set_flags;
      cmd.write_reg  = 1'b1;
      cmd.keep_carry = (imm12[11:10] == 2'b00);
      cmd.imm        = cmd.keep_carry ? rep_val : rot_val;
      cmd.rot_carry  = rot_val[31];
      cmd.logic_op   = tli_pkg::LOGIC_AND;
      unique case (req_chan.opcode)
         tli_pkg::OP_TST: begin
            cmd.reject    = (req_chan.source_reg == tli_pkg::PC_REG);
            cmd.write_reg = 1'b0;
            cmd.set_flags = 1'b1;
         end
         tli_pkg::OP_AND: begin
            cmd.reject = (req_chan.source_reg == tli_pkg::PC_REG) ||
                         (req_chan.dest_reg == tli_pkg::PC_REG);
         end
         tli_pkg::OP_BIC: begin
            cmd.reject   = (req_chan.source_reg == tli_pkg::PC_REG) ||
                           (req_chan.dest_reg == tli_pkg::PC_REG);
            cmd.logic_op = tli_pkg::LOGIC_BIC;
         end
         tli_pkg::OP_MOV: begin
            cmd.reject   = (req_chan.dest_reg == tli_pkg::PC_REG);
            cmd.logic_op = tli_pkg::LOGIC_MOV;
         end
         tli_pkg::OP_ORR: begin
            cmd.reject   = (req_chan.source_reg == tli_pkg::PC_REG) ||
                           (req_chan.dest_reg == tli_pkg::PC_REG);
            cmd.logic_op = tli_pkg::LOGIC_ORR;
         end
         default: begin
            cmd.reject = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/tli_queue.sv
`default_nettype none
module tli_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tli_pkg::tli_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output tli_pkg::tli_cmd_type head_cmd
);

   tli_pkg::tli_cmd_type             entry_ff [tli_pkg::QueueDepth];
   logic [tli_pkg::QPtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tli_pkg::QPtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tli_pkg::QCntW-1:0]        count_ff, count_in;

   assign full       = (count_ff == tli_pkg::QCntW'(tli_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### sv/tli_back.sv
`default_nettype none
module tli_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  tli_pkg::tli_cmd_type head_cmd,
   output logic                 pop,
   tli_rsp_if.source            rsp_chan
);

   logic [tli_pkg::DataW-1:0] reg_file_ff [tli_pkg::NumRegs];
   logic                      flag_n_ff, flag_n_in;
   logic                      flag_z_ff, flag_z_in;
   logic                      flag_c_ff, flag_c_in;
   logic                      out_valid_ff, out_valid_in;
   logic [tli_pkg::DataW-1:0] out_result_ff, out_result_in;
   logic                      out_written_ff, out_written_in;
   logic                      out_unpred_ff, out_unpred_in;
   logic [tli_pkg::DataW-1:0] operand;
   logic                      do_write;

   // output slot free or being emptied this cycle
   assign pop = head_valid && (!out_valid_ff || rsp_chan.ready);

   assign operand = (head_cmd.src != tli_pkg::PC_REG) ? reg_file_ff[head_cmd.src] : '0;

   always_comb begin
      unique case (head_cmd.logic_op)
         tli_pkg::LOGIC_AND: out_result_in = operand & head_cmd.imm;
         tli_pkg::LOGIC_BIC: out_result_in = operand & ~head_cmd.imm;
         tli_pkg::LOGIC_MOV: out_result_in = head_cmd.imm;
         default:            out_result_in = operand | head_cmd.imm;
      endcase
      if (head_cmd.reject) begin
         out_result_in = '0;
      end
      out_written_in = head_cmd.write_reg && !head_cmd.reject;
      out_unpred_in  = head_cmd.reject;
      do_write       = pop && out_written_in;

      flag_n_in = flag_n_ff;
      flag_z_in = flag_z_ff;
      flag_c_in = flag_c_ff;
      if (head_cmd.set_flags && !head_cmd.reject) begin
         flag_n_in = out_result_in[tli_pkg::DataW-1];
         flag_z_in = (out_result_in == '0);
         flag_c_in = head_cmd.keep_carry ? flag_c_ff : head_cmd.rot_carry;
      end

      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < tli_pkg::NumRegs; k++) begin
            reg_file_ff[k] <= '0;
         end
         flag_n_ff    <= 1'b0;
         flag_z_ff    <= 1'b0;
         flag_c_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            flag_n_ff <= flag_n_in;
            flag_z_ff <= flag_z_in;
            flag_c_ff <= flag_c_in;
         end
         if (do_write) begin
            reg_file_ff[head_cmd.dest] <= out_result_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_result_ff  <= out_result_in;
         out_written_ff <= out_written_in;
         out_unpred_ff  <= out_unpred_in;
      end
   end

   // flags register reflects the word just produced, so present it with it
   logic out_n_ff, out_z_ff, out_c_ff;
   always_ff @(posedge clock) begin
      if (pop) begin
         out_n_ff <= flag_n_in;
         out_z_ff <= flag_z_in;
         out_c_ff <= flag_c_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_value  = out_result_ff;
   assign rsp_chan.reg_written   = out_written_ff;
   assign rsp_chan.negative_flag = out_n_ff;
   assign rsp_chan.zero_flag     = out_z_ff;
   assign rsp_chan.carry_flag    = out_c_ff;
   assign rsp_chan.unpredictable = out_unpred_ff;

endmodule
`default_nettype wire

### sv/thumb2_logical_immediate_unit_top.sv
// Thumb-2 logical instruction unit with modified immediate (TST/AND/BIC/MOV/ORR).
//
// Channels: req_chan takes one instruction word per valid/ready handshake;
// rsp_chan returns exactly one result word per instruction, in order.
// Front end decodes the word, flags PC use and unused opcodes, and expands
// the 12-bit immediate. A two-word queue decouples it from the back end,
// which owns the 15-entry register file and the N/Z/C flags.
//
// Order: the accepting edge writes the queue; the back end then executes the
// queue head into the output register, raising rsp valid, once that register
// is free or being emptied. Throughput: one word per cycle while the receiver
// takes results; the back end reads registers and flags and writes them back
// in the same cycle, so dependent words follow each other with no bubble.
//
// Reset (synchronous, active high): registers r0..r14 and all flags clear,
// queue and output slot empty. No initialization sweep.
//
// Receiver stall: the output register holds its word; the back end stops
// draining the queue, and req ready drops once the queue's two slots fill.
`default_nettype none
module thumb2_logical_immediate_unit_top (
   input  logic      clock,
   input  logic      reset,
   tli_req_if.sink   req_chan,
   tli_rsp_if.source rsp_chan
);

   tli_pkg::tli_cmd_type front_cmd;
   tli_pkg::tli_cmd_type head_cmd;
   logic                 push;
   logic                 queue_full;
   logic                 pop;
   logic                 head_valid;

   // decode and immediate expansion
   tli_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (front_cmd)
   );

   // decoupling queue
   tli_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // register file, flags, result register
   tli_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire

### sv/tli_checker.sv
`default_nettype none
module tli_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic        rsp_reg_written,
   input logic        rsp_unpredictable
);

   logic [2:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   // a result word must stem from an accepted request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result word without outstanding request");

   // rejected instructions write nothing and report zero
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unpredictable |-> !rsp_reg_written && rsp_result_value == 32'd0)
      else $error("unpredictable word carries data or a write");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("stalled result word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind thumb2_logical_immediate_unit_top tli_checker u_tli_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_result_value  (rsp_chan.result_value),
   .rsp_reg_written   (rsp_chan.reg_written),
   .rsp_unpredictable (rsp_chan.unpredictable)
);
`default_nettype wire

### tb/thumb2_logical_immediate_unit_top_tb.sv
`timescale 1ns / 100ps
module thumb2_logical_immediate_unit_top_tb;

   // what one result word carries
   typedef struct packed {
      logic [31:0] value;
      logic        written;
      logic        neg;
      logic        zero;
      logic        carry;
      logic        unpred;
   } tli_result_type;

   localparam int StallLimit = 5000;   // cycles with no word accepted on either side

   logic clock;
   logic reset;

   tli_req_if req_bus ();
   tli_rsp_if rsp_bus ();

   thumb2_logical_immediate_unit_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // model state: r0..r14 and the flags
   logic [31:0] gpr [tli_pkg::NumRegs];
   logic        flag_n;
   logic        flag_z;
   logic        flag_c;

   tli_result_type expected_results [$];
   int          errors;
   int          stall_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Modified-immediate expansion plus the logical op; updates the model state
   // and returns the result word the unit must produce.
   function automatic tli_result_type execute_logical(input logic [2:0] op, input logic s,
                                                      input logic [3:0] rn,
                                                      input logic [3:0] rd,
                                                      input logic [11:0] imm12);
      tli_result_type r;
      logic        reject;
      logic        writes;
      logic        upd;
      logic        cout;
      logic [7:0]  b;
      logic [31:0] imm;
      logic [31:0] base;
      logic [31:0] operand;
      logic [63:0] dbl;
      r = '0;
      writes = 1'b1;
      upd = s;
      b = imm12[7:0];
      case (tli_pkg::tli_opcode_type'(op))
         tli_pkg::OP_TST: begin
            reject = (rn == tli_pkg::PC_REG);
            writes = 1'b0;
            upd = 1'b1;   // TST always sets flags
         end
         tli_pkg::OP_AND, tli_pkg::OP_BIC, tli_pkg::OP_ORR:
            reject = (rn == tli_pkg::PC_REG) || (rd == tli_pkg::PC_REG);
         tli_pkg::OP_MOV: reject = (rd == tli_pkg::PC_REG);   // MOV ignores rn
         default: reject = 1'b1;            // unused opcodes
      endcase

      if (reject) begin
         // rejected: nothing changes, flags shown as they stand
         r.unpred = 1'b1;
      end else begin
         if (imm12[11:10] == 2'b00) begin
            // replicated byte, carry passes through
            case (imm12[9:8])
               2'd0: imm = {24'h0, b};
               2'd1: imm = {8'h0, b, 8'h0, b};
               2'd2: imm = {b, 8'h0, b, 8'h0};
               default: imm = {4{b}};
            endcase
            cout = flag_c;
         end else begin
            // 1:imm7 rotated right by imm12[11:7] (always >= 8 here)
            base = {24'h0, 1'b1, imm12[6:0]};
            dbl = {base, base} >> imm12[11:7];
            imm = dbl[31:0];
            cout = imm[31];
         end
         operand = (rn == tli_pkg::PC_REG) ? 32'h0 : gpr[rn];
         case (tli_pkg::tli_opcode_type'(op))
            tli_pkg::OP_BIC: r.value = operand & ~imm;
            tli_pkg::OP_MOV: r.value = imm;
            tli_pkg::OP_ORR: r.value = operand | imm;
            default: r.value = operand & imm;
         endcase
         if (writes)
            gpr[rd] = r.value;
         if (upd) begin
            flag_n = r.value[31];
            flag_z = (r.value == 32'h0);
            flag_c = cout;
         end
         r.written = writes;
      end
      r.neg = flag_n;
      r.zero = flag_z;
      r.carry = flag_c;
      return r;
   endfunction

   // drive one instruction word; prediction is taken at the accepting edge
   task automatic send_instr(input logic [2:0] op, input logic s, input logic [3:0] rn,
                             input logic [3:0] rd, input logic [11:0] imm12);
      tli_result_type exp_word;
      while ($urandom_range(99) < send_idle_pct)
         @(negedge clock);
      req_bus.opcode = op;
      req_bus.set_flags = s;
      req_bus.source_reg = rn;
      req_bus.dest_reg = rd;
      req_bus.imm_top_bit = imm12[11];
      req_bus.imm_mid_bits = imm12[10:8];
      req_bus.imm_low_byte = imm12[7:0];
      req_bus.valid = 1'b1;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      exp_word = execute_logical(op, s, rn, rd, imm12);
      expected_results.push_back(exp_word);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      end
   endfunction

   // receiver: random back-pressure, changed on the falling edge
   always @(negedge clock)
      rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);

   // result checker and stall counter, sampled at the rising edge
   always @(posedge clock) begin
      tli_result_type want;
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, value %h", $time,
                     rsp_bus.result_value);
         end else begin
            want = expected_results.pop_front();
            compare_field("result_value", want.value, rsp_bus.result_value);
            compare_field("reg_written", 32'(want.written), 32'(rsp_bus.reg_written));
            compare_field("negative_flag", 32'(want.neg), 32'(rsp_bus.negative_flag));
            compare_field("zero_flag", 32'(want.zero), 32'(rsp_bus.zero_flag));
            compare_field("carry_flag", 32'(want.carry), 32'(rsp_bus.carry_flag));
            compare_field("unpredictable", 32'(want.unpred), 32'(rsp_bus.unpredictable));
         end
      end
   end

   // watchdog: ends the run when the channels stop moving
   initial begin
      stall_cycles = 0;
      while (stall_cycles < StallLimit)
         @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // immediate expansion corners on every legal op: replicated patterns,
   // zero byte keeping C, smallest and largest rotation
   task automatic test_immediate_expansion();
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd0, 4'd0, 12'h000);    // zero byte, C kept
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd0, 4'd1, 12'h0FF);
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd0, 4'd2, 12'h1AB);
      send_instr(tli_pkg::OP_MOV, 1'b0, 4'd0, 4'd3, 12'h2CD);
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd0, 4'd4, 12'h3FF);    // all ones, N set
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd0, 4'd5, 12'h400);    // rotate by 8, C set
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd0, 4'd6, 12'hFFF);    // rotate by 31, C clear
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd0, 4'd7, 12'h500);    // rotate, bit 31 clear
      send_instr(tli_pkg::OP_AND, 1'b1, 4'd4, 4'd8, 12'h0FF);
      send_instr(tli_pkg::OP_BIC, 1'b1, 4'd4, 4'd9, 12'h3FF);    // clears to zero, Z set
      send_instr(tli_pkg::OP_ORR, 1'b1, 4'd0, 4'd14, 12'h800);
      send_instr(tli_pkg::OP_TST, 1'b0, 4'd4, 4'd15, 12'h400);   // TST sets flags
      send_instr(tli_pkg::OP_AND, 1'b0, 4'd1, 4'd2, 12'h155);
      send_instr(tli_pkg::OP_ORR, 1'b0, 4'd2, 4'd10, 12'h2F0);
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd15, 4'd11, 12'h7FF);  // MOV does not read rn
   endtask

   // PC use as rn or rd on each op (BIC only as rd) and the unused opcodes
   task automatic test_pc_and_unused();
      send_instr(tli_pkg::OP_TST, 1'b1, 4'd15, 4'd0, 12'h0FF);
      send_instr(tli_pkg::OP_AND, 1'b0, 4'd1, 4'd15, 12'h0FF);
      send_instr(tli_pkg::OP_AND, 1'b1, 4'd15, 4'd1, 12'h0FF);
      send_instr(tli_pkg::OP_BIC, 1'b1, 4'd1, 4'd15, 12'h0FF);
      send_instr(tli_pkg::OP_MOV, 1'b1, 4'd1, 4'd15, 12'h400);
      send_instr(tli_pkg::OP_ORR, 1'b1, 4'd15, 4'd1, 12'h3FF);
      send_instr(tli_pkg::OP_ORR, 1'b0, 4'd1, 4'd15, 12'h3FF);
      send_instr(3'd5, 1'b1, 4'd1, 4'd2, 12'hFFF);
      send_instr(3'd6, 1'b0, 4'd3, 4'd4, 12'h000);
      send_instr(3'd7, 1'b1, 4'd14, 4'd14, 12'h800);
   endtask

   // mixed traffic; registers lean toward r0..r3 so words depend on each other
   task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int count);
      logic [2:0] op;
      logic [3:0] rn;
      logic [3:0] rd;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int k = 0; k < count; k++) begin
         op = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         rn = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
         rd = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
         send_instr(op, 1'($urandom_range(1)), rn, rd, 12'($urandom_range(4095)));
      end
   endtask

   // sender holds off until the unit has fully drained, then resumes
   task automatic test_quiet_pause();
      test_random_traffic(send_idle_pct, recv_idle_pct, 10);
      wait_for_results();
      repeat (4) @(negedge clock);
      test_random_traffic(send_idle_pct, recv_idle_pct, 10);
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 9;
      recv_idle_pct = 66;
      flag_n = 1'b0;
      flag_z = 1'b0;
      flag_c = 1'b0;
      for (int k = 0; k < tli_pkg::NumRegs; k++)
         gpr[k] = 32'h0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.set_flags = 1'b0;
      req_bus.source_reg = '0;
      req_bus.dest_reg = '0;
      req_bus.imm_top_bit = 1'b0;
      req_bus.imm_mid_bits = '0;
      req_bus.imm_low_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_immediate_expansion();
      test_pc_and_unused();
      test_random_traffic(9, 66, 420);
      test_random_traffic(66, 9, 420);
      test_quiet_pause();
      test_random_traffic(0, 0, 420);

      // all words sent: let the pipe empty, then idle before the verdict
      wait_for_results();
      repeat (4) @(negedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
sv/tli_pkg.sv
sv/tli_channels.sv
sv/tli_front.sv
sv/tli_queue.sv
sv/tli_back.sv
sv/thumb2_logical_immediate_unit_top.sv
sv/tli_checker.sv
tb/thumb2_logical_immediate_unit_top_tb.sv
